// ----- hw/rtl/hcb_pkg.sv -----
package hcb_pkg;

    localparam int LEN_W  = 6;
    localparam int DIST_W = 9;
    localparam int ORIG_W = 23;
    localparam int COMP_W = 25;
    localparam int WORD_W = 32;

    typedef enum logic [1:0] {
        CMD_COUNT  = 2'd0,
        CMD_BUILD  = 2'd1,
        CMD_ENCODE = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_LIMIT     = 2'd1,
        STS_NOT_BUILT = 2'd2,
        STS_EMPTY     = 2'd3
    } t_sts_code;

    typedef enum logic [21:0] {
        S_IDLE   = 22'h000001,
        S_CNT_RD = 22'h000002,
        S_CNT_WR = 22'h000004,
        S_ENC_RD = 22'h000008,
        S_ENC_EV = 22'h000010,
        S_BI_RD  = 22'h000020,
        S_BI_WR  = 22'h000040,
        S_M_CHK  = 22'h000080,
        S_SC_RD  = 22'h000100,
        S_SC_EV  = 22'h000200,
        S_TAKE   = 22'h000400,
        S_MRG_W  = 22'h000800,
        S_MRG_P1 = 22'h001000,
        S_MRG_P2 = 22'h002000,
        S_CD_RD  = 22'h004000,
        S_CD_HV  = 22'h008000,
        S_D_RD   = 22'h010000,
        S_D_EV   = 22'h020000,
        S_C_RD   = 22'h040000,
        S_C_EV   = 22'h080000,
        S_FIN    = 22'h100000,
        S_RESP   = 22'h200000
    } t_state;

    typedef struct packed {
        t_cmd cmd;
        logic at_limit;
        logic sym_ok;
        logic total_zero;
        logic built;
        logic out_busy;
        logic live_gt1;
        logic scan_end;
        logic second;
        logic sym_last;
        logic hv_zero;
        logic p_zero;
        logic pos_zero;
    } t_dp_sts;

endpackage

// ----- hw/rtl/hcb_ram.sv -----
module hcb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- hw/rtl/hcb_ctrl.sv -----
module hcb_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  hcb_pkg::t_dp_sts i_sts,
    output hcb_pkg::t_state  o_state
);
    import hcb_pkg::*;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    unique case (i_sts.cmd)
                        CMD_COUNT:  n_state = (i_sts.at_limit || !i_sts.sym_ok) ? S_RESP : S_CNT_RD;
                        CMD_BUILD:  n_state = i_sts.total_zero ? S_RESP : S_BI_RD;
                        CMD_ENCODE: n_state = (i_sts.built && i_sts.sym_ok) ? S_ENC_RD : S_RESP;
                        default:    n_state = S_RESP;
                    endcase
                end
            end
            S_CNT_RD: n_state = S_CNT_WR;
            S_CNT_WR: n_state = S_RESP;
            S_ENC_RD: n_state = S_ENC_EV;
            S_ENC_EV: n_state = S_RESP;
            S_BI_RD:  n_state = S_BI_WR;
            S_BI_WR:  n_state = i_sts.sym_last ? S_M_CHK : S_BI_RD;
            S_M_CHK:  n_state = i_sts.live_gt1 ? S_SC_RD : S_CD_RD;
            S_SC_RD:  n_state = S_SC_EV;
            S_SC_EV:  n_state = i_sts.scan_end ? S_TAKE : S_SC_RD;
            S_TAKE:   n_state = i_sts.second ? S_MRG_W : S_SC_RD;
            S_MRG_W:  n_state = S_MRG_P1;
            S_MRG_P1: n_state = S_MRG_P2;
            S_MRG_P2: n_state = S_M_CHK;
            S_CD_RD:  n_state = S_CD_HV;
            S_CD_HV: begin
                if (!i_sts.hv_zero) begin
                    n_state = S_D_RD;
                end else begin
                    n_state = i_sts.sym_last ? S_FIN : S_CD_RD;
                end
            end
            S_D_RD:   n_state = S_D_EV;
            S_D_EV:   n_state = i_sts.p_zero ? S_C_RD : S_D_RD;
            S_C_RD:   n_state = S_C_EV;
            S_C_EV: begin
                if (!(i_sts.p_zero || i_sts.pos_zero)) begin
                    n_state = S_C_RD;
                end else begin
                    n_state = i_sts.sym_last ? S_FIN : S_CD_RD;
                end
            end
            S_FIN:    n_state = S_RESP;
            S_RESP:   n_state = i_sts.out_busy ? S_RESP : S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_state = r_state;
endmodule

// ----- hw/rtl/hcb_dp.sv -----
module hcb_dp #(
    parameter int ALPHABET_SIZE = 256,
    parameter int COUNT_BITS    = 20,
    parameter int MAX_CODE_BITS = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  hcb_pkg::t_state                i_state,
    input  logic                           i_valid,
    input  logic [1:0]                     i_command,
    input  logic [7:0]                     i_symbol,
    input  logic                           i_ready,
    output hcb_pkg::t_dp_sts               o_sts,
    output logic                           o_valid,
    output logic [1:0]                     o_status,
    output logic [hcb_pkg::WORD_W-1:0]     o_code_word,
    output logic [hcb_pkg::LEN_W-1:0]      o_code_length,
    output logic [hcb_pkg::DIST_W-1:0]     o_distinct_symbols,
    output logic [hcb_pkg::ORIG_W-1:0]     o_original_bits,
    output logic [hcb_pkg::COMP_W-1:0]     o_compressed_bits
);
    import hcb_pkg::*;

    localparam int NODES  = 2 * ALPHABET_SIZE - 1;
    localparam int SYM_W  = $clog2(ALPHABET_SIZE);
    localparam int NODE_W = $clog2(NODES);
    localparam int PAR_W  = NODE_W + 1;
    localparam int WT_W   = COUNT_BITS + 1;
    localparam int CT_W   = MAX_CODE_BITS + LEN_W;
    localparam int PROD_W = COUNT_BITS + LEN_W;

    logic [ALPHABET_SIZE-1:0] r_hvld;
    logic                     r_hvld_q;
    logic [COUNT_BITS-1:0]    r_total;
    logic                     r_built;
    logic [7:0]               r_sym;
    logic [NODE_W-1:0]        r_idx, r_next, r_live, r_best, r_a, r_node, r_depth, r_pos;
    logic [COUNT_BITS-1:0]    r_bw, r_wa, r_h;
    logic                     r_have, r_second;
    logic [LEN_W-1:0]         r_keep;
    logic [MAX_CODE_BITS-1:0] r_code;
    logic [DIST_W-1:0]        r_distinct;
    logic [COMP_W-1:0]        r_comp;

    logic [1:0]          r_res_status;
    logic [WORD_W-1:0]   r_res_word;
    logic [LEN_W-1:0]    r_res_len;
    logic [DIST_W-1:0]   r_res_dist;
    logic [ORIG_W-1:0]   r_res_orig;
    logic [COMP_W-1:0]   r_res_comp;

    logic                  h_we, w_we, p_we, c_we;
    logic [SYM_W-1:0]      h_raddr, c_waddr, sym_a, idx_s;
    logic [COUNT_BITS-1:0] h_rdata, h_wdata, hv;
    logic [NODE_W-1:0]     w_waddr, p_waddr;
    logic [WT_W-1:0]       w_wdata, w_rdata;
    logic [PAR_W-1:0]      p_wdata, p_rdata;
    logic [CT_W-1:0]       c_wdata, c_rdata;
    logic [NODE_W-1:0]     pos_n;
    logic [PROD_W-1:0]     prod;
    logic                  accept, side;

    assign sym_a  = r_sym[SYM_W-1:0];
    assign idx_s  = r_idx[SYM_W-1:0];
    assign hv     = r_hvld_q ? h_rdata : '0;
    assign accept = (i_state == S_IDLE) && i_valid;
    assign pos_n  = r_pos - 1'b1;
    assign side   = p_rdata[0];
    assign prod   = PROD_W'(r_h) * PROD_W'(r_keep);

    assign h_raddr = (i_state == S_CNT_RD) ? sym_a : idx_s;
    assign h_we    = (i_state == S_CNT_WR);
    assign h_wdata = hv + 1'b1;

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_idx;
        w_wdata = {(hv != '0), hv};
        p_we    = 1'b0;
        p_waddr = r_idx;
        p_wdata = '0;
        c_we    = 1'b0;
        c_waddr = idx_s;
        c_wdata = '0;
        unique case (i_state)
            S_BI_WR: begin
                w_we = 1'b1;
                p_we = 1'b1;
            end
            S_TAKE: begin
                w_we    = 1'b1;
                w_waddr = r_best;
                w_wdata = {1'b0, r_bw};
            end
            S_MRG_W: begin
                w_we    = 1'b1;
                w_waddr = r_next;
                w_wdata = {1'b1, r_wa + r_bw};
                p_we    = 1'b1;
                p_waddr = r_a;
                p_wdata = {r_next, 1'b0};
            end
            S_MRG_P1: begin
                p_we    = 1'b1;
                p_waddr = r_best;
                p_wdata = {r_next, 1'b1};
            end
            S_MRG_P2: begin
                p_we    = 1'b1;
                p_waddr = r_next;
            end
            S_CD_HV: c_we = (hv == '0);
            S_C_EV: begin
                c_we    = (p_rdata == '0) || (r_pos == '0);
                c_wdata = {r_code, r_keep};
            end
            default: ;
        endcase
    end

    hcb_ram #(.WIDTH(COUNT_BITS), .DEPTH(ALPHABET_SIZE)) u_hist (
        .i_clk(i_clk), .i_we(h_we), .i_waddr(sym_a), .i_wdata(h_wdata),
        .i_raddr(h_raddr), .o_rdata(h_rdata)
    );
    hcb_ram #(.WIDTH(WT_W), .DEPTH(NODES)) u_weight (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_raddr(r_idx), .o_rdata(w_rdata)
    );
    hcb_ram #(.WIDTH(PAR_W), .DEPTH(NODES)) u_parent (
        .i_clk(i_clk), .i_we(p_we), .i_waddr(p_waddr), .i_wdata(p_wdata),
        .i_raddr(r_node), .o_rdata(p_rdata)
    );
    hcb_ram #(.WIDTH(CT_W), .DEPTH(ALPHABET_SIZE)) u_code (
        .i_clk(i_clk), .i_we(c_we), .i_waddr(c_waddr), .i_wdata(c_wdata),
        .i_raddr(sym_a), .o_rdata(c_rdata)
    );

    always_comb begin
        o_sts.cmd        = t_cmd'(i_command);
        o_sts.at_limit   = (r_total == '1);
        o_sts.sym_ok     = (9'(i_symbol) < 9'(ALPHABET_SIZE));
        o_sts.total_zero = (r_total == '0);
        o_sts.built      = r_built;
        o_sts.out_busy   = o_valid && !i_ready;
        o_sts.live_gt1   = (r_live > NODE_W'(1));
        o_sts.scan_end   = (r_idx == NODE_W'(r_next - 1'b1));
        o_sts.second     = r_second;
        o_sts.sym_last   = (r_idx == NODE_W'(ALPHABET_SIZE - 1));
        o_sts.hv_zero    = (hv == '0);
        o_sts.p_zero     = (p_rdata == '0);
        o_sts.pos_zero   = (r_pos == '0);
    end

    always_ff @(posedge i_clk) begin
        r_hvld_q <= r_hvld[h_raddr];
        if (!i_rst_n) begin
            r_hvld  <= '0;
            r_total <= '0;
            r_built <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            if (o_valid && i_ready && (i_state != S_RESP)) begin
                o_valid <= 1'b0;
            end
            if (accept) begin
                r_sym      <= i_symbol;
                r_res_word <= '0;
                r_res_len  <= '0;
                r_res_dist <= '0;
                r_res_orig <= '0;
                r_res_comp <= '0;
                r_idx      <= '0;
                r_live     <= '0;
                r_distinct <= '0;
                r_comp     <= '0;
                unique case (t_cmd'(i_command))
                    CMD_COUNT:  r_res_status <= (r_total == '1) ? STS_LIMIT : STS_OK;
                    CMD_BUILD:  r_res_status <= (r_total == '0) ? STS_EMPTY : STS_OK;
                    CMD_ENCODE: r_res_status <= r_built ? STS_OK : STS_NOT_BUILT;
                    default: begin
                        r_res_status <= STS_OK;
                        r_hvld       <= '0;
                        r_total      <= '0;
                        r_built      <= 1'b0;
                    end
                endcase
            end
            unique case (i_state)
                S_CNT_WR: begin
                    r_hvld[sym_a] <= 1'b1;
                    r_total       <= r_total + 1'b1;
                    r_built       <= 1'b0;
                end
                S_ENC_EV: begin
                    r_res_word <= WORD_W'(c_rdata[LEN_W +: MAX_CODE_BITS]);
                    r_res_len  <= c_rdata[LEN_W-1:0];
                end
                S_BI_WR: begin
                    r_live <= r_live + NODE_W'(hv != '0);
                    r_idx  <= r_idx + 1'b1;
                    r_next <= NODE_W'(ALPHABET_SIZE);
                end
                S_M_CHK: begin
                    r_idx    <= '0;
                    r_have   <= 1'b0;
                    r_second <= 1'b0;
                end
                S_SC_EV: begin
                    if (w_rdata[COUNT_BITS] && (!r_have || w_rdata[COUNT_BITS-1:0] < r_bw)) begin
                        r_best <= r_idx;
                        r_bw   <= w_rdata[COUNT_BITS-1:0];
                        r_have <= 1'b1;
                    end
                    r_idx <= r_idx + 1'b1;
                end
                S_TAKE: begin
                    if (!r_second) begin
                        r_a      <= r_best;
                        r_wa     <= r_bw;
                        r_second <= 1'b1;
                        r_have   <= 1'b0;
                        r_idx    <= '0;
                    end
                end
                S_MRG_P2: begin
                    r_next <= r_next + 1'b1;
                    r_live <= r_live - 1'b1;
                end
                S_CD_HV: begin
                    if (hv == '0) begin
                        r_idx <= r_idx + 1'b1;
                    end else begin
                        r_h     <= hv;
                        r_node  <= r_idx;
                        r_depth <= '0;
                    end
                end
                S_D_EV: begin
                    if (p_rdata != '0) begin
                        r_node  <= p_rdata[PAR_W-1:1];
                        r_depth <= r_depth + 1'b1;
                    end else begin
                        r_keep <= (int'(r_depth) > MAX_CODE_BITS) ?
                                  LEN_W'(MAX_CODE_BITS) : LEN_W'(r_depth);
                        r_node <= r_idx;
                        r_pos  <= r_depth;
                        r_code <= '0;
                    end
                end
                S_C_EV: begin
                    if ((p_rdata != '0) && (r_pos != '0)) begin
                        r_pos  <= pos_n;
                        r_node <= p_rdata[PAR_W-1:1];
                        if (side && (int'(pos_n) < int'(r_keep))) begin
                            r_code <= r_code | (MAX_CODE_BITS'(1) <<
                                      (int'(r_keep) - 1 - int'(pos_n)));
                        end
                    end else begin
                        r_comp     <= r_comp + COMP_W'(prod);
                        r_distinct <= r_distinct + 1'b1;
                        r_idx      <= r_idx + 1'b1;
                    end
                end
                S_FIN: begin
                    r_res_dist <= r_distinct;
                    r_res_comp <= r_comp;
                    r_res_orig <= ORIG_W'({r_total, 3'b000});
                    r_built    <= 1'b1;
                end
                S_RESP: begin
                    if (!o_valid || i_ready) begin
                        o_valid            <= 1'b1;
                        o_status           <= r_res_status;
                        o_code_word        <= r_res_word;
                        o_code_length      <= r_res_len;
                        o_distinct_symbols <= r_res_dist;
                        o_original_bits    <= r_res_orig;
                        o_compressed_bits  <= r_res_comp;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

// ----- hw/rtl/huffman_code_builder_encoder_top.sv -----
// Static Huffman coder over a byte alphabet.
// Input channel (i_valid/o_ready) carries a command and a symbol; output
// channel (o_valid/i_ready) returns exactly one result item per input item.
// o_ready is high only while the controller is idle; one item is in work at
// a time, and the next item may be accepted while a result waits on a stall.
// Work per item: clear and refused items go straight to the response; encode
// reads the code table; count reads the histogram entry and writes it back.
// Build loads the leaves over every alphabet entry, then per merge makes two
// scans over every node made so far, then visits every alphabet entry and, per
// counted symbol, walks to the root twice; each step reads the node memories
// one entry at a time.
// Only one item is in work at a time; the next item can be accepted in the
// cycle after the result register is loaded.
// Result register parts the channels: a stalled receiver holds the finished
// item, the block finishes no further item until it is taken.
// Reset (synchronous, active low) empties the histogram through per-entry
// valid bits, zeroes the total and drops the built flag; no clearing pass.
// Clear command does the same.
module huffman_code_builder_encoder_top #(
    parameter int ALPHABET_SIZE = 256,
    parameter int COUNT_BITS    = 20,
    parameter int MAX_CODE_BITS = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [1:0]                     i_command,
    input  logic [7:0]                     i_symbol,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [1:0]                     o_status,
    output logic [hcb_pkg::WORD_W-1:0]     o_code_word,
    output logic [hcb_pkg::LEN_W-1:0]      o_code_length,
    output logic [hcb_pkg::DIST_W-1:0]     o_distinct_symbols,
    output logic [hcb_pkg::ORIG_W-1:0]     o_original_bits,
    output logic [hcb_pkg::COMP_W-1:0]     o_compressed_bits
);
    import hcb_pkg::*;

    t_state  state;
    t_dp_sts sts;

    hcb_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid),
        .i_sts(sts), .o_state(state)
    );

    hcb_dp #(
        .ALPHABET_SIZE(ALPHABET_SIZE),
        .COUNT_BITS(COUNT_BITS),
        .MAX_CODE_BITS(MAX_CODE_BITS)
    ) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_state(state),
        .i_valid(i_valid), .i_command(i_command), .i_symbol(i_symbol),
        .i_ready(i_ready), .o_sts(sts), .o_valid(o_valid),
        .o_status(o_status), .o_code_word(o_code_word),
        .o_code_length(o_code_length), .o_distinct_symbols(o_distinct_symbols),
        .o_original_bits(o_original_bits), .o_compressed_bits(o_compressed_bits)
    );

    assign o_ready = (state == S_IDLE);

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (state != S_IDLE))
        else $error("accepted item did not start work");

    a_result_from_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(state == S_RESP))
        else $error("result appeared outside response state");

    a_built_needs_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sts.built |-> !sts.total_zero)
        else $error("codes marked built with empty histogram");
endmodule

// ----- sim/tb.sv -----
module tb;
    import hcb_pkg::*;

    localparam int NSYM    = 256;
    localparam int NNODE   = 2 * NSYM - 1;
    localparam int CNT_MAX = (1 << 20) - 1;
    localparam int MAXLEN  = 32;
    localparam int N_ITEMS = 1050;

    typedef struct packed {
        t_sts_code          sts;
        logic [WORD_W-1:0]  word;
        logic [LEN_W-1:0]   len;
        logic [DIST_W-1:0]  ndist;
        logic [ORIG_W-1:0]  orig;
        logic [COMP_W-1:0]  comp;
    } t_result;

    typedef struct packed {
        t_cmd        cmd;
        logic [7:0]  sym;
        logic        typed;
        t_result     res;
    } t_row;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_ready;
    logic [1:0]          i_command;
    logic [7:0]          i_symbol;
    logic                o_valid;
    logic                i_ready;
    logic [1:0]          o_status;
    logic [WORD_W-1:0]   o_code_word;
    logic [LEN_W-1:0]    o_code_length;
    logic [DIST_W-1:0]   o_distinct_symbols;
    logic [ORIG_W-1:0]   o_original_bits;
    logic [COMP_W-1:0]   o_compressed_bits;

    huffman_code_builder_encoder_top dut (.*);

    // predictor state
    int          hist [NSYM];
    int          total;
    bit          built;
    logic [31:0] tbl_word [NSYM];
    int          tbl_len [NSYM];

    t_result     pending_q [$];
    int          errors;
    int          n_sent, n_checked, n_builds, n_encodes, n_counts, max_len_seen;
    bit          calm, hold_req, hold_done;
    int          stall_left;

    always begin
        i_clk = 1'b1; #4;
        i_clk = 1'b0; #4;
    end

    function automatic int lightest(ref bit live[NNODE], ref int wt[NNODE], input int lim);
        int best;
        best = -1;
        for (int i = 0; i < lim; i++)
            if (live[i] && (best < 0 || wt[i] < wt[best])) best = i;
        return best;
    endfunction

    function automatic t_result huff_step(t_cmd c, logic [7:0] s);
        t_result r;
        bit      live [NNODE];
        int      wt [NNODE];
        int      par [NNODE];
        bit      side [NNODE];
        int      nlive, nxt, a, b, depth, keep, node, pos;
        logic [31:0] code;
        longint  comp;
        r = '0;
        r.sts = STS_OK;
        case (c)
            CMD_COUNT: begin
                if (total >= CNT_MAX) r.sts = STS_LIMIT;
                else begin
                    hist[s]++;
                    total++;
                    built = 0;
                end
            end
            CMD_BUILD: begin
                if (total == 0) r.sts = STS_EMPTY;
                else begin
                    nlive = 0;
                    comp = 0;
                    for (int i = 0; i < NNODE; i++) begin
                        live[i] = 0; par[i] = -1; side[i] = 0; wt[i] = 0;
                    end
                    for (int i = 0; i < NSYM; i++) begin
                        wt[i] = hist[i];
                        if (hist[i] != 0) begin live[i] = 1; nlive++; end
                    end
                    nxt = NSYM;
                    while (nlive > 1 && nxt < NNODE) begin
                        a = lightest(live, wt, nxt);
                        live[a] = 0;
                        b = lightest(live, wt, nxt);
                        live[b] = 0;
                        wt[nxt] = wt[a] + wt[b];
                        par[a] = nxt; side[a] = 0;
                        par[b] = nxt; side[b] = 1;
                        live[nxt] = 1;
                        nxt++;
                        nlive--;
                    end
                    for (int i = 0; i < NSYM; i++) begin
                        tbl_word[i] = 0;
                        tbl_len[i] = 0;
                        if (hist[i] != 0) begin
                            depth = 0;
                            node = i;
                            while (par[node] >= 0) begin node = par[node]; depth++; end
                            keep = (depth > MAXLEN) ? MAXLEN : depth;
                            code = 0;
                            node = i;
                            pos = depth;
                            while (pos > 0) begin
                                pos--;
                                if (pos < keep && side[node]) code[keep-1-pos] = 1'b1;
                                node = par[node];
                            end
                            tbl_word[i] = code;
                            tbl_len[i] = keep;
                            if (keep > max_len_seen) max_len_seen = keep;
                            r.ndist = r.ndist + 1'b1;
                            comp += longint'(hist[i]) * keep;
                        end
                    end
                    r.orig = ORIG_W'(total * 8);
                    r.comp = COMP_W'(comp);
                    built = 1;
                end
            end
            CMD_ENCODE: begin
                if (!built) r.sts = STS_NOT_BUILT;
                else begin
                    r.word = tbl_word[s];
                    r.len = LEN_W'(tbl_len[s]);
                end
            end
            default: begin
                foreach (hist[i]) hist[i] = 0;
                total = 0;
                built = 0;
            end
        endcase
        return r;
    endfunction

    function automatic t_result mk(t_sts_code st, int d, int o, int cb);
        t_result r;
        r = '0;
        r.sts = st; r.ndist = DIST_W'(d); r.orig = ORIG_W'(o); r.comp = COMP_W'(cb);
        return r;
    endfunction

    task automatic offer(t_cmd c, logic [7:0] s, t_result r);
        while (!calm && $urandom_range(0, 99) < 28) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_command <= c;
        i_symbol  <= s;
        do @(posedge i_clk); while (!o_ready);
        pending_q.push_back(r);
        n_sent++;
        case (c)
            CMD_BUILD:  n_builds++;
            CMD_ENCODE: n_encodes++;
            CMD_COUNT:  n_counts++;
            default: ;
        endcase
        calm = (n_sent >= 300 && n_sent < 450);
        if (n_sent == 520) hold_req = 1;
    endtask

    task automatic issue(t_cmd c, logic [7:0] s);
        offer(c, s, huff_step(c, s));
    endtask

    function automatic void check_result(t_result e);
        t_result got;
        got.sts   = t_sts_code'(o_status);
        got.word  = o_code_word;
        got.len   = o_code_length;
        got.ndist = o_distinct_symbols;
        got.orig  = o_original_bits;
        got.comp  = o_compressed_bits;
        if (got != e) begin
            errors++;
            if (errors <= 10) begin
                $display("mismatch item %0d: exp sts=%0d word=%h len=%0d dist=%0d orig=%0d comp=%0d",
                         n_checked, e.sts, e.word, e.len, e.ndist, e.orig, e.comp);
                $display("    got sts=%0d word=%h len=%0d dist=%0d orig=%0d comp=%0d",
                         got.sts, got.word, got.len, got.ndist, got.orig, got.comp);
            end
        end
    endfunction

    // receiver
    initial begin
        i_ready = 1'b0;
        stall_left = 0;
        hold_done = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                if (pending_q.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("result with no item outstanding");
                end else
                    check_result(pending_q.pop_front());
                n_checked++;
            end
            if (hold_req && !hold_done) begin
                hold_done = 1;
                stall_left = 400;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else
                i_ready <= calm || ($urandom_range(0, 99) >= 28);
        end
    end

    initial begin
        #200000000;
        $display("CHECKS FAILED");
        $finish;
    end

    // stimulus
    initial begin
        t_row        rows [$];
        t_result     z;
        t_result     r;
        int          nset, nc, kind, wait_n;
        logic [7:0]  set [$];
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_command = CMD_CLEAR;
        i_symbol = '0;
        errors = 0;
        n_sent = 0; n_checked = 0; n_builds = 0; n_encodes = 0; n_counts = 0;
        max_len_seen = 0;
        calm = 0; hold_req = 0;
        total = 0; built = 0;
        foreach (hist[i]) begin hist[i] = 0; tbl_word[i] = 0; tbl_len[i] = 0; end
        z = mk(STS_OK, 0, 0, 0);

        rows.push_back('{CMD_ENCODE, 8'd5,   1, mk(STS_NOT_BUILT, 0, 0, 0)});
        rows.push_back('{CMD_BUILD,  8'd0,   1, mk(STS_EMPTY, 0, 0, 0)});
        rows.push_back('{CMD_COUNT,  8'd0,   1, z});
        rows.push_back('{CMD_BUILD,  8'd0,   1, mk(STS_OK, 1, 8, 0)});
        rows.push_back('{CMD_ENCODE, 8'd0,   1, z});
        rows.push_back('{CMD_COUNT,  8'd255, 1, z});
        rows.push_back('{CMD_COUNT,  8'd255, 1, z});
        rows.push_back('{CMD_BUILD,  8'd0,   0, z});
        rows.push_back('{CMD_ENCODE, 8'd0,   0, z});
        rows.push_back('{CMD_ENCODE, 8'd255, 0, z});
        rows.push_back('{CMD_ENCODE, 8'd17,  1, z});
        rows.push_back('{CMD_COUNT,  8'd17,  1, z});
        rows.push_back('{CMD_ENCODE, 8'd17,  1, mk(STS_NOT_BUILT, 0, 0, 0)});
        rows.push_back('{CMD_CLEAR,  8'd255, 1, z});
        rows.push_back('{CMD_ENCODE, 8'd0,   1, mk(STS_NOT_BUILT, 0, 0, 0)});
        rows.push_back('{CMD_BUILD,  8'd0,   1, mk(STS_EMPTY, 0, 0, 0)});
        rows.push_back('{CMD_COUNT,  8'd1,   0, z});
        rows.push_back('{CMD_COUNT,  8'd2,   0, z});
        rows.push_back('{CMD_COUNT,  8'd3,   0, z});
        rows.push_back('{CMD_COUNT,  8'd4,   0, z});
        rows.push_back('{CMD_COUNT,  8'd4,   0, z});
        rows.push_back('{CMD_COUNT,  8'd128, 0, z});
        rows.push_back('{CMD_BUILD,  8'd0,   0, z});
        rows.push_back('{CMD_ENCODE, 8'd1,   0, z});
        rows.push_back('{CMD_ENCODE, 8'd128, 0, z});

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[k]) begin
            r = huff_step(rows[k].cmd, rows[k].sym);
            offer(rows[k].cmd, rows[k].sym, rows[k].typed ? rows[k].res : r);
        end

        // one build over the whole alphabet
        issue(CMD_CLEAR, 8'd0);
        for (int v = 0; v < NSYM; v++) issue(CMD_COUNT, 8'(v));
        issue(CMD_COUNT, 8'd0);
        issue(CMD_BUILD, 8'd0);
        repeat (6) issue(CMD_ENCODE, 8'($urandom_range(0, 255)));

        while (n_sent < N_ITEMS) begin
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
                // noise
                issue(t_cmd'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            end else begin
                if (kind > 2) issue(CMD_CLEAR, 8'($urandom_range(0, 255)));
                set.delete();
                nset = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 24 : 8);
                repeat (nset) set.push_back(8'($urandom_range(0, 255)));
                nc = $urandom_range(1, 40);
                repeat (nc)
                    issue(CMD_COUNT, set[$urandom_range(0, $urandom_range(0, nset - 1))]);
                issue(CMD_BUILD, 8'($urandom_range(0, 255)));
                repeat ($urandom_range(2, 10)) begin
                    if ($urandom_range(0, 4) == 0)
                        issue(CMD_ENCODE, 8'($urandom_range(0, 255)));
                    else
                        issue(CMD_ENCODE, set[$urandom_range(0, nset - 1)]);
                end
            end
        end
        @(posedge i_clk);
        i_valid <= 1'b0;

        wait_n = 0;
        while (pending_q.size() != 0 && wait_n < 2000000) begin
            @(posedge i_clk);
            wait_n++;
        end
        repeat (50) @(posedge i_clk);
        if (pending_q.size() != 0) begin
            errors++;
            $display("%0d results never arrived", pending_q.size());
        end
        $display("%0d items sent (%0d counts, %0d builds, %0d encodes), %0d results checked",
                 n_sent, n_counts, n_builds, n_encodes, n_checked);
        $display("longest code seen %0d bits, %0d mismatches", max_len_seen, errors);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/hcb_pkg.sv
hw/rtl/hcb_ram.sv
hw/rtl/hcb_ctrl.sv
hw/rtl/hcb_dp.sv
hw/rtl/huffman_code_builder_encoder_top.sv
sim/tb.sv
